// ----- src/hrsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsd_pkg
// Shared types, codes and character helpers for the response stream decoder.
// ----------------------------------------------------------------------------
package hrsd_pkg;

  // Default sizes
  localparam int unsigned WORD_WIDTH_DEF      = 32;
  localparam int unsigned ACK_COUNT_WIDTH_DEF = 16;
  localparam int unsigned LIMIT_W             = 4;
  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST = 4'd3;

  // Request modes
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_CLR_ACK = 2'd1;
  localparam logic [1:0] MODE_CLR_INT = 2'd2;

  // Command letters
  localparam logic [7:0] CMD_ADDR  = 8'h41;  // 'A'
  localparam logic [7:0] CMD_READ  = 8'h52;  // 'R'
  localparam logic [7:0] CMD_IDLE  = 8'h5a;  // 'Z'
  localparam logic [7:0] CMD_ACK   = 8'h4b;  // 'K'
  localparam logic [7:0] CMD_RESET = 8'h54;  // 'T'
  localparam logic [7:0] CMD_INT   = 8'h49;  // 'I'
  localparam logic [7:0] CMD_ERR   = 8'h45;  // 'E'

  localparam logic [6:0] FILL_CHAR = 7'h7f;

  typedef enum logic [2:0] {
    EV_READ  = 3'd0,
    EV_ACK   = 3'd1,
    EV_INT   = 3'd2,
    EV_ERROR = 3'd3,
    EV_ADDR  = 3'd4,
    EV_RESET = 3'd5,
    EV_ABORT = 3'd6
  } hrsd_event_t;

  // Flags and event code that travel with a result
  typedef struct packed {
    hrsd_event_t event_res;
    logic        address_valid;
    logic        address_increments;
    logic        interrupt_pending;
    logic        bus_error_seen;
  } hrsd_status_t;

  // '0'..'9' or 'a'..'f'
  function automatic logic is_hex_digit(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66);
  endfunction

  // Nibble value of a hex digit; letters sit at low nibble 1..6
  function automatic logic [3:0] hex_value(input logic [7:0] b);
    return (b <= 8'h39) ? b[3:0] : (b[3:0] + 4'd9);
  endfunction

  // Space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
  endfunction

endpackage

// ----- src/hrsd_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsd_in_stage
// Input register: holds one request until the decode stage consumes it.
// ----------------------------------------------------------------------------
module hrsd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       req_valid,
  output logic [1:0] req_mode,
  output logic [7:0] req_byte
);
  import hrsd_pkg::*;

  logic       valid_r;
  logic [1:0] mode_r;
  logic [7:0] byte_r;

  assign in_ready  = !valid_r || advance;
  assign req_valid = valid_r;
  assign req_mode  = mode_r;
  assign req_byte  = byte_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      byte_r <= in_rx_byte;
    end
  end

endmodule

// ----- src/hrsd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsd_core
// Decode of one request against the tracked bus state; emits at most one event.
// ----------------------------------------------------------------------------
module hrsd_core #(
  parameter int unsigned WORD_WIDTH      = hrsd_pkg::WORD_WIDTH_DEF,
  parameter int unsigned ACK_COUNT_WIDTH = hrsd_pkg::ACK_COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [hrsd_pkg::LIMIT_W-1:0]  cfg_wr_data,
  input  logic                          fire,
  input  logic [1:0]                    req_mode,
  input  logic [7:0]                    req_byte,
  output logic                          ev_valid,
  output hrsd_pkg::hrsd_status_t        ev_status,
  output logic [WORD_WIDTH-1:0]         ev_data,
  output logic [WORD_WIDTH-1:0]         ev_address,
  output logic [ACK_COUNT_WIDTH-1:0]    ev_ack_total
);
  import hrsd_pkg::*;

  logic [LIMIT_W-1:0]         limit_r,    limit_nxt;
  logic [WORD_WIDTH-1:0]      acc_r,      acc_nxt;
  logic [7:0]                 pend_r,     pend_nxt;
  logic                       space_r,    space_nxt;
  logic [WORD_WIDTH-1:0]      addr_r,     addr_nxt;
  logic                       known_r,    known_nxt;
  logic                       incr_r,     incr_nxt;
  logic [ACK_COUNT_WIDTH-1:0] ack_r,      ack_nxt;
  logic                       int_r,      int_nxt;
  logic                       err_r,      err_nxt;
  logic [LIMIT_W-1:0]         idle_r,     idle_nxt;
  hrsd_event_t                evt;
  logic [WORD_WIDTH-1:0]      data;

  // Next-state decode
  always_comb begin
    limit_nxt = limit_r;
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    space_nxt = space_r;
    addr_nxt  = addr_r;
    known_nxt = known_r;
    incr_nxt  = incr_r;
    ack_nxt   = ack_r;
    int_nxt   = int_r;
    err_nxt   = err_r;
    idle_nxt  = idle_r;
    ev_valid  = 1'b0;
    evt       = EV_READ;
    data      = '0;

    if (cfg_wr_en) begin
      limit_nxt = cfg_wr_data;
      idle_nxt  = cfg_wr_data;
    end else if (fire) begin
      case (req_mode)
        MODE_CLR_ACK: ack_nxt = '0;
        MODE_CLR_INT: int_nxt = 1'b0;
        MODE_BYTE: begin
          if (req_byte[6:0] == FILL_CHAR) begin
            // idle fill, dropped
          end else if (is_hex_digit(req_byte)) begin
            space_nxt = 1'b0;
            acc_nxt   = {acc_r[WORD_WIDTH-5:0], hex_value(req_byte)};
          end else begin
            // Close the pending response
            if (!space_r) begin
              case (pend_r)
                CMD_READ: begin
                  if (incr_r) addr_nxt = addr_r + WORD_WIDTH'(4);
                  data     = acc_r;
                  idle_nxt = limit_r;
                  evt      = EV_READ;
                  ev_valid = 1'b1;
                end
                CMD_ACK: begin
                  if (incr_r) addr_nxt = addr_r + WORD_WIDTH'(4);
                  if (ack_r != '1) ack_nxt = ack_r + ACK_COUNT_WIDTH'(1);
                  evt      = EV_ACK;
                  ev_valid = 1'b1;
                end
                CMD_INT: begin
                  int_nxt  = 1'b1;
                  evt      = EV_INT;
                  ev_valid = 1'b1;
                end
                CMD_ERR: begin
                  err_nxt  = 1'b1;
                  evt      = EV_ERROR;
                  ev_valid = 1'b1;
                end
                CMD_IDLE: begin
                  if (idle_r <= LIMIT_W'(1)) begin
                    idle_nxt = limit_r;
                    evt      = EV_ABORT;
                    ev_valid = 1'b1;
                  end else begin
                    idle_nxt = idle_r - LIMIT_W'(1);
                  end
                end
                CMD_ADDR: begin
                  known_nxt = 1'b1;
                  incr_nxt  = !acc_r[0];
                  addr_nxt  = {acc_r[WORD_WIDTH-1:2], 2'b00};
                  data      = {acc_r[WORD_WIDTH-1:2], 2'b00};
                  evt       = EV_ADDR;
                  ev_valid  = 1'b1;
                end
                CMD_RESET: begin
                  known_nxt = 1'b0;
                  err_nxt   = 1'b0;
                  evt       = EV_RESET;
                  ev_valid  = 1'b1;
                end
                default: ;
              endcase
            end
            // Whitespace never becomes a command
            if (is_blank(req_byte)) begin
              space_nxt = 1'b1;
            end else begin
              pend_nxt  = req_byte;
              space_nxt = 1'b0;
            end
            acc_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Result fields reflect state after this request
  assign ev_status.event_res          = evt;
  assign ev_status.address_valid      = known_nxt;
  assign ev_status.address_increments = incr_nxt;
  assign ev_status.interrupt_pending  = int_nxt;
  assign ev_status.bus_error_seen     = err_nxt;
  assign ev_data      = data;
  assign ev_address   = addr_nxt;
  assign ev_ack_total = ack_nxt;

  // Tracked state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= IDLE_LIMIT_RST;
      acc_r   <= '0;
      pend_r  <= '0;
      space_r <= 1'b1;
      addr_r  <= '0;
      known_r <= 1'b0;
      incr_r  <= 1'b0;
      ack_r   <= '0;
      int_r   <= 1'b0;
      err_r   <= 1'b0;
      idle_r  <= IDLE_LIMIT_RST;
    end else begin
      limit_r <= limit_nxt;
      acc_r   <= acc_nxt;
      pend_r  <= pend_nxt;
      space_r <= space_nxt;
      addr_r  <= addr_nxt;
      known_r <= known_nxt;
      incr_r  <= incr_nxt;
      ack_r   <= ack_nxt;
      int_r   <= int_nxt;
      err_r   <= err_nxt;
      idle_r  <= idle_nxt;
    end
  end

  // Events come only from a consumed request
  a_ev_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid |-> fire)
    else $error("event without a consumed request");

  // Error event leaves the sticky flag set
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_valid && ev_status.event_res == EV_ERROR) |=> err_r)
    else $error("error flag not set after error event");

  // Ack counter moves only on a consumed request
  a_ack_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(ack_r))
    else $error("ack counter changed without a request");

endmodule

// ----- src/hrsd_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsd_out_stage
// Result register: holds one event until the consumer takes it.
// ----------------------------------------------------------------------------
module hrsd_out_stage #(
  parameter int unsigned WORD_WIDTH      = hrsd_pkg::WORD_WIDTH_DEF,
  parameter int unsigned ACK_COUNT_WIDTH = hrsd_pkg::ACK_COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  output logic                          take,
  input  logic                          ev_load,
  input  hrsd_pkg::hrsd_status_t        ev_status,
  input  logic [WORD_WIDTH-1:0]         ev_data,
  input  logic [WORD_WIDTH-1:0]         ev_address,
  input  logic [ACK_COUNT_WIDTH-1:0]    ev_ack_total,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hrsd_pkg::hrsd_status_t        out_status,
  output logic [WORD_WIDTH-1:0]         out_data,
  output logic [WORD_WIDTH-1:0]         out_address,
  output logic [ACK_COUNT_WIDTH-1:0]    out_ack
);
  import hrsd_pkg::*;

  logic                       valid_r;
  hrsd_status_t               status_r;
  logic [WORD_WIDTH-1:0]      data_r;
  logic [WORD_WIDTH-1:0]      addr_r;
  logic [ACK_COUNT_WIDTH-1:0] ack_r;

  // Register is free when empty or drained this cycle
  assign take        = !valid_r || out_ready;
  assign out_valid   = valid_r;
  assign out_status  = status_r;
  assign out_data    = data_r;
  assign out_address = addr_r;
  assign out_ack     = ack_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= ev_load;
    end
  end

  always_ff @(posedge clk) begin
    if (take && ev_load) begin
      status_r <= ev_status;
      data_r   <= ev_data;
      addr_r   <= ev_address;
      ack_r    <= ev_ack_total;
    end
  end

endmodule

// ----- src/hex_response_stream_decoder_unit.sv -----
`timescale 1ns / 1ps
// An accepted request is decoded from the input register into the result register.
// Throughput: one request per cycle; the input register, the decode and the result
// register form a two-register pipeline that stalls only when the result is not taken.
// Reset (rst_n low, synchronous): pipeline emptied, decoder state cleared, idle
// limit and idle countdown set to 3.
// ----------------------------------------------------------------------------
// hex_response_stream_decoder_unit
// Decodes a hex-coded bus response byte stream into bus events.
// ----------------------------------------------------------------------------
module hex_response_stream_decoder_unit #(
  parameter int unsigned WORD_WIDTH      = hrsd_pkg::WORD_WIDTH_DEF,
  parameter int unsigned ACK_COUNT_WIDTH = hrsd_pkg::ACK_COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [hrsd_pkg::LIMIT_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_event_res,
  output logic [WORD_WIDTH-1:0]         out_data_word,
  output logic [WORD_WIDTH-1:0]         out_current_address,
  output logic                          out_address_valid,
  output logic                          out_address_increments,
  output logic [ACK_COUNT_WIDTH-1:0]    out_ack_total,
  output logic                          out_interrupt_pending,
  output logic                          out_bus_error_seen
);
  import hrsd_pkg::*;

  logic                       take;
  logic                       req_valid;
  logic [1:0]                 req_mode;
  logic [7:0]                 req_byte;
  logic                       fire;
  logic                       ev_valid;
  hrsd_status_t               ev_status;
  logic [WORD_WIDTH-1:0]      ev_data;
  logic [WORD_WIDTH-1:0]      ev_address;
  logic [ACK_COUNT_WIDTH-1:0] ev_ack_total;
  hrsd_status_t               out_status;

  // Decode a held request once the result register can take its outcome
  assign fire = req_valid && take;

  hrsd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_rx_byte (in_rx_byte),
    .advance    (take),
    .req_valid  (req_valid),
    .req_mode   (req_mode),
    .req_byte   (req_byte)
  );

  hrsd_core #(
    .WORD_WIDTH      (WORD_WIDTH),
    .ACK_COUNT_WIDTH (ACK_COUNT_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fire         (fire),
    .req_mode     (req_mode),
    .req_byte     (req_byte),
    .ev_valid     (ev_valid),
    .ev_status    (ev_status),
    .ev_data      (ev_data),
    .ev_address   (ev_address),
    .ev_ack_total (ev_ack_total)
  );

  hrsd_out_stage #(
    .WORD_WIDTH      (WORD_WIDTH),
    .ACK_COUNT_WIDTH (ACK_COUNT_WIDTH)
  ) u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .ev_load      (ev_valid),
    .ev_status    (ev_status),
    .ev_data      (ev_data),
    .ev_address   (ev_address),
    .ev_ack_total (ev_ack_total),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_data     (out_data_word),
    .out_address  (out_current_address),
    .out_ack      (out_ack_total)
  );

  // Unpack status flags onto the result ports
  assign out_event_res          = out_status.event_res;
  assign out_address_valid      = out_status.address_valid;
  assign out_address_increments = out_status.address_increments;
  assign out_interrupt_pending  = out_status.interrupt_pending;
  assign out_bus_error_seen     = out_status.bus_error_seen;

endmodule

// ----- sim/hex_response_stream_decoder_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_response_stream_decoder_unit_tb
// Self-checking bench for the response stream decoder. A short directed table
// covers fill bytes, blanks, every response letter, the idle abort and the
// clear requests; random response streams follow under several idle limits and
// handshake profiles. Every accepted request runs through a local decoder
// model and each result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module hex_response_stream_decoder_unit_tb;
  import hrsd_pkg::*;

  localparam int unsigned WW = WORD_WIDTH_DEF;
  localparam int unsigned AW = ACK_COUNT_WIDTH_DEF;
  localparam logic [1:0]  MODE_UNUSED     = 2'd3;
  localparam int          NUM_DIRECTED    = 25;
  localparam int          NUM_PHASES      = 6;
  localparam int          ITEMS_PER_PHASE = 242;
  localparam int          SETTLE_CYCLES   = 4;
  localparam int          HOLD_CYCLES     = 64;
  localparam int          MAX_REPORTS     = 200;
  localparam int          TIMEOUT_NS      = 5_000_000;

  // One decoded bus event as it leaves the block
  typedef struct packed {
    hrsd_event_t   ev;
    logic [WW-1:0] data;
    logic [WW-1:0] addr;
    logic          addr_ok;
    logic          addr_inc;
    logic [AW-1:0] acks;
    logic          irq;
    logic          err;
  } decoded_t;

  // Directed request, with a hand-written result where one is pinned
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx;
    logic       pinned;
    decoded_t   res;
  } stim_row_t;

  localparam decoded_t NO_RESULT = '0;

  // Clock, reset and block inputs
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic [1:0] in_mode = MODE_BYTE;
  logic [7:0] in_rx_byte = 8'h00;
  logic out_ready = 1'b0;

  // Block outputs
  logic in_ready;
  logic out_valid;
  logic [2:0] out_event_res;
  logic [WW-1:0] out_data_word;
  logic [WW-1:0] out_current_address;
  logic out_address_valid;
  logic out_address_increments;
  logic [AW-1:0] out_ack_total;
  logic out_interrupt_pending;
  logic out_bus_error_seen;

  // Decoder model state
  logic [LIMIT_W-1:0] idle_limit = IDLE_LIMIT_RST;
  logic [LIMIT_W-1:0] idle_left = IDLE_LIMIT_RST;
  logic [WW-1:0]      word_acc = '0;
  logic [7:0]         cmd_letter = 8'h00;
  logic               blank_seen = 1'b1;
  logic [WW-1:0]      trk_addr = '0;
  logic               trk_addr_known = 1'b0;
  logic               trk_step = 1'b0;
  logic [AW-1:0]      ack_cnt = '0;
  logic               irq_flag = 1'b0;
  logic               err_flag = 1'b0;

  decoded_t pending_events [$];
  int       mismatch_count = 0;
  int       requests_sent = 0;
  int       tx_idle_pct = 17;
  int       rx_idle_pct = 73;
  logic     pressure_req = 1'b0;
  logic     hold_armed = 1'b0;
  int       hold_left = 0;

  logic [LIMIT_W-1:0] phase_limits [NUM_PHASES] = '{4'd15, 4'd1, 4'd0, 4'd8, 4'd3, 4'd2};

  // Reset state, fill, blanks, every letter, idle abort, clears, unknown letter
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{MODE_BYTE,    8'h00,     1'b0, NO_RESULT},  // ignored closer after reset
    '{MODE_BYTE,    8'hff,     1'b0, NO_RESULT},  // fill with top bit set
    '{MODE_BYTE,    8'h7f,     1'b0, NO_RESULT},  // plain fill
    '{MODE_BYTE,    CMD_ADDR,  1'b0, NO_RESULT},  // closes unknown NUL command
    '{MODE_BYTE,    "9",       1'b0, NO_RESULT},
    '{MODE_BYTE,    "a",       1'b0, NO_RESULT},
    '{MODE_BYTE,    CMD_READ,  1'b1,
      '{EV_ADDR,  32'h98, 32'h98, 1'b1, 1'b1, 16'd0, 1'b0, 1'b0}},
    '{MODE_BYTE,    "0",       1'b0, NO_RESULT},
    '{MODE_BYTE,    "f",       1'b0, NO_RESULT},
    '{MODE_BYTE,    CMD_ACK,   1'b1,
      '{EV_READ,  32'h0f, 32'h9c, 1'b1, 1'b1, 16'd0, 1'b0, 1'b0}},
    '{MODE_BYTE,    " ",       1'b1,
      '{EV_ACK,   32'h00, 32'ha0, 1'b1, 1'b1, 16'd1, 1'b0, 1'b0}},
    '{MODE_BYTE,    8'h09,     1'b0, NO_RESULT},  // tab after space: ignored
    '{MODE_BYTE,    CMD_INT,   1'b0, NO_RESULT},
    '{MODE_BYTE,    CMD_ERR,   1'b1,
      '{EV_INT,   32'h00, 32'ha0, 1'b1, 1'b1, 16'd1, 1'b1, 1'b0}},
    '{MODE_BYTE,    CMD_IDLE,  1'b1,
      '{EV_ERROR, 32'h00, 32'ha0, 1'b1, 1'b1, 16'd1, 1'b1, 1'b1}},
    '{MODE_BYTE,    CMD_IDLE,  1'b0, NO_RESULT},
    '{MODE_BYTE,    CMD_IDLE,  1'b0, NO_RESULT},
    '{MODE_BYTE,    CMD_IDLE,  1'b1,
      '{EV_ABORT, 32'h00, 32'ha0, 1'b1, 1'b1, 16'd1, 1'b1, 1'b1}},
    '{MODE_CLR_ACK, CMD_ADDR,  1'b0, NO_RESULT},  // byte ignored
    '{MODE_CLR_INT, 8'hff,     1'b0, NO_RESULT},
    '{MODE_UNUSED,  "9",       1'b0, NO_RESULT},  // unused mode does nothing
    '{MODE_BYTE,    CMD_RESET, 1'b0, NO_RESULT},
    '{MODE_BYTE,    8'h0d,     1'b1,
      '{EV_RESET, 32'h00, 32'ha0, 1'b0, 1'b1, 16'd0, 1'b0, 1'b0}},
    '{MODE_BYTE,    "q",       1'b0, NO_RESULT},  // unknown command letter
    '{MODE_BYTE,    8'h0c,     1'b0, NO_RESULT}   // closes it: no effect
  };

  hex_response_stream_decoder_unit dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_mode                (in_mode),
    .in_rx_byte             (in_rx_byte),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_event_res          (out_event_res),
    .out_data_word          (out_data_word),
    .out_current_address    (out_current_address),
    .out_address_valid      (out_address_valid),
    .out_address_increments (out_address_increments),
    .out_ack_total          (out_ack_total),
    .out_interrupt_pending  (out_interrupt_pending),
    .out_bus_error_seen     (out_bus_error_seen)
  );

  always #10 clk = ~clk;

  // Decode one accepted request; returns 1 when it produces a bus event
  function automatic bit decode_request(input logic [1:0] m, input logic [7:0] b,
                                        output decoded_t r);
    bit fire;
    r = NO_RESULT;
    fire = 1'b0;
    if (m == MODE_CLR_ACK) begin
      ack_cnt = '0;
      return 1'b0;
    end
    if (m == MODE_CLR_INT) begin
      irq_flag = 1'b0;
      return 1'b0;
    end
    if (m != MODE_BYTE || b[6:0] == FILL_CHAR) return 1'b0;

    // hex digit: shift in, keep the low word
    if ((b >= "0" && b <= "9") || (b >= "a" && b <= "f")) begin
      word_acc = {word_acc[WW-5:0], 4'((b <= "9") ? b - "0" : b - "a" + 8'd10)};
      blank_seen = 1'b0;
      return 1'b0;
    end

    // any other byte closes the pending response unless a blank came first
    if (!blank_seen) begin
      case (cmd_letter)
        CMD_READ: begin
          if (trk_step) trk_addr = trk_addr + 4;
          r.data = word_acc;
          idle_left = idle_limit;
          r.ev = EV_READ;
          fire = 1'b1;
        end
        CMD_ACK: begin
          if (trk_step) trk_addr = trk_addr + 4;
          if (ack_cnt != '1) ack_cnt = ack_cnt + 1'b1;
          r.ev = EV_ACK;
          fire = 1'b1;
        end
        CMD_INT: begin
          irq_flag = 1'b1;
          r.ev = EV_INT;
          fire = 1'b1;
        end
        CMD_ERR: begin
          err_flag = 1'b1;
          r.ev = EV_ERROR;
          fire = 1'b1;
        end
        CMD_IDLE: begin
          // a zero limit acts like one
          if (idle_left <= 1) begin
            idle_left = idle_limit;
            r.ev = EV_ABORT;
            fire = 1'b1;
          end else begin
            idle_left = idle_left - 1'b1;
          end
        end
        CMD_ADDR: begin
          trk_addr_known = 1'b1;
          trk_step = ~word_acc[0];
          trk_addr = {word_acc[WW-1:2], 2'b00};
          r.data = trk_addr;
          r.ev = EV_ADDR;
          fire = 1'b1;
        end
        CMD_RESET: begin
          trk_addr_known = 1'b0;
          err_flag = 1'b0;
          r.ev = EV_RESET;
          fire = 1'b1;
        end
        default: ;
      endcase
    end

    // blanks never become a command
    if (b == " " || (b >= 8'h09 && b <= 8'h0d)) begin
      blank_seen = 1'b1;
    end else begin
      cmd_letter = b;
      blank_seen = 1'b0;
    end
    word_acc = '0;

    r.addr     = trk_addr;
    r.addr_ok  = trk_addr_known;
    r.addr_inc = trk_step;
    r.acks     = ack_cnt;
    r.irq      = irq_flag;
    r.err      = err_flag;
    return fire;
  endfunction

  // Offer one request, wait for acceptance, queue the expected event
  task automatic send_request(input logic [1:0] m, input logic [7:0] b,
                              input bit pinned = 1'b0, input decoded_t pin = NO_RESULT);
    decoded_t r;
    bit       fired;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= m;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    fired = decode_request(m, b, r);
    if (pinned) begin
      r = pin;
      fired = 1'b1;
    end
    if (fired) pending_events.push_back(r);
  endtask

  // One random response: letter, digits, optional blanks; or a noise request
  task automatic send_random_response();
    int          reps;
    int          ndig;
    logic [31:0] value;
    logic [7:0]  letter;
    logic [3:0]  nib;
    if ($urandom_range(99) < 12) begin
      case ($urandom_range(4))
        0:       send_request(MODE_CLR_ACK, 8'($urandom_range(255)));
        1:       send_request(MODE_CLR_INT, 8'($urandom_range(255)));
        2:       send_request(MODE_UNUSED, 8'($urandom_range(255)));
        3:       send_request(MODE_BYTE, {1'($urandom_range(1)), FILL_CHAR});
        default: send_request(MODE_BYTE, 8'($urandom_range(255)));
      endcase
      return;
    end

    case ($urandom_range(13))
      0, 1:     letter = CMD_ADDR;
      2, 3:     letter = CMD_READ;
      4, 5:     letter = CMD_ACK;
      6:        letter = CMD_INT;
      7:        letter = CMD_ERR;
      8, 9, 10: letter = CMD_IDLE;
      11:       letter = CMD_RESET;
      12:       letter = 8'($urandom_range(8'h5a, 8'h47));  // 'G'..'Z', mostly unknown
      default:  letter = {1'b1, CMD_READ[6:0]};            // high bit set: unknown
    endcase
    // idle letters often come in long runs to reach the abort
    reps = (letter == CMD_IDLE && $urandom_range(3) == 0) ? $urandom_range(20, 2) : 1;
    repeat (reps) send_request(MODE_BYTE, letter);

    value = $urandom();
    if (letter == CMD_ADDR || letter == CMD_READ) begin
      // top of the address space so increments wrap
      if ($urandom_range(3) == 0) value = {28'hfffffff, 4'($urandom_range(15))};
      ndig = ($urandom_range(2) != 0) ? 8 : $urandom_range(10, 1);
    end else begin
      ndig = ($urandom_range(9) < 7) ? 0 : $urandom_range(3);
    end
    // digits past the eighth fall off the top of the word
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = (i < 8) ? 4'(value >> (4 * i)) : 4'($urandom_range(15));
      send_request(MODE_BYTE, (nib < 4'd10) ? "0" + 8'(nib) : "a" + 8'(nib) - 8'd10);
    end

    if ($urandom_range(99) < 35) begin
      repeat ($urandom_range(2, 1))
        send_request(MODE_BYTE, ($urandom_range(5) == 0) ? " " : 8'($urandom_range(13, 9)));
    end
  endtask

  // Wait until every expected event is back and the pipeline has emptied
  task automatic drain_results();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random back-pressure plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (pressure_req && !hold_armed) begin
      hold_armed <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    decoded_t got;
    decoded_t want;
    if (rst_n && out_valid && out_ready) begin
      got.ev       = hrsd_event_t'(out_event_res);
      got.data     = out_data_word;
      got.addr     = out_current_address;
      got.addr_ok  = out_address_valid;
      got.addr_inc = out_address_increments;
      got.acks     = out_ack_total;
      got.irq      = out_interrupt_pending;
      got.err      = out_bus_error_seen;
      if (pending_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result ev=%0d data=%h addr=%h", $time,
                   got.ev, got.data, got.addr);
      end else begin
        want = pending_events.pop_front();
        if (got.ev !== want.ev || got.data !== want.data || got.addr !== want.addr ||
            got.addr_ok !== want.addr_ok || got.addr_inc !== want.addr_inc ||
            got.acks !== want.acks || got.irq !== want.irq || got.err !== want.err) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch expected ev=%0d data=%h addr=%h av=%b inc=%b ack=%0d",
                     $time, want.ev, want.data, want.addr, want.addr_ok, want.addr_inc,
                     want.acks, " irq=%b err=%b | actual ev=%0d data=%h addr=%h", want.irq,
                     want.err, got.ev, got.data, got.addr,
                     " av=%b inc=%b ack=%0d irq=%b err=%b", got.addr_ok, got.addr_inc,
                     got.acks, got.irq, got.err);
        end
      end
    end
  end

  // Main sequence
  initial begin
    int phase_target;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, sender idle 17%, receiver idle 73%
    foreach (directed_rows[i])
      send_request(directed_rows[i].mode, directed_rows[i].rx,
                   directed_rows[i].pinned, directed_rows[i].res);
    in_valid <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= phase_limits[ph];
      @(posedge clk);
      cfg_wr_en  <= 1'b0;
      idle_limit = phase_limits[ph];
      idle_left  = phase_limits[ph];

      // idle profile: A, A, B, B, none, none
      case (ph / 2)
        0: begin
          tx_idle_pct = 17;
          rx_idle_pct <= 73;
        end
        1: begin
          tx_idle_pct = 73;
          rx_idle_pct <= 17;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      // long receiver hold while requests keep coming
      if (ph == 4) pressure_req <= 1'b1;

      phase_target = requests_sent + ITEMS_PER_PHASE;
      while (requests_sent < phase_target) send_random_response();
      in_valid <= 1'b0;
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("[hex_response_stream_decoder_unit] OK");
    end else begin
      $display("[hex_response_stream_decoder_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("[hex_response_stream_decoder_unit] ERROR");
    $finish;
  end

endmodule
